FILE: rtl/fcs_pkg.sv
// ---------------------------------------------------------------------------
// fcs_pkg
// Shared types, register codes and constants of the follow camera smoother.
// ---------------------------------------------------------------------------
package fcs_pkg;

	localparam int NUM_LANES = 6;
	localparam int AXES      = 3;

	typedef enum logic [2:0] {
		REG_CAM_X  = 3'd0,
		REG_CAM_Y  = 3'd1,
		REG_CAM_Z  = 3'd2,
		REG_LOOK_X = 3'd3,
		REG_LOOK_Y = 3'd4,
		REG_LOOK_Z = 3'd5,
		REG_SMOOTH = 3'd6
	} reg_idx_t;

	localparam logic [15:0] SMOOTH_RESET = 16'd1280;

	// exact floor division of a 32-bit value by 5 and by 3
	localparam logic [31:0] RECIP5     = 32'hCCCC_CCCD;
	localparam logic [31:0] RECIP3     = 32'hAAAA_AAAB;
	localparam logic [31:0] ONE_Q31    = 32'h8000_0000;
	localparam logic [31:0] EXP_M1_Q31 = 32'd790015084;

	localparam logic [19:0]        INV_GAIN_Q20 = 20'd636748;
	localparam logic signed [31:0] DEG180_Q16   = 32'sd11796480;

	typedef struct packed {
		logic load_des;
		logic prime;
		logic mul;
		logic upd;
	} lane_ctrl_t;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else if (v < -36'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	// atan(2^-i) in degrees, Q.16
	function automatic logic [21:0] atan_deg_q16(input logic [4:0] idx);
		logic [21:0] r;
		case (idx)
			5'd0:    r = 22'd2949120;
			5'd1:    r = 22'd1740967;
			5'd2:    r = 22'd919879;
			5'd3:    r = 22'd466945;
			5'd4:    r = 22'd234379;
			5'd5:    r = 22'd117304;
			5'd6:    r = 22'd58666;
			5'd7:    r = 22'd29335;
			5'd8:    r = 22'd14668;
			5'd9:    r = 22'd7334;
			5'd10:   r = 22'd3667;
			5'd11:   r = 22'd1833;
			5'd12:   r = 22'd917;
			5'd13:   r = 22'd458;
			5'd14:   r = 22'd229;
			5'd15:   r = 22'd115;
			5'd16:   r = 22'd57;
			5'd17:   r = 22'd29;
			5'd18:   r = 22'd14;
			5'd19:   r = 22'd7;
			5'd20:   r = 22'd4;
			5'd21:   r = 22'd2;
			5'd22:   r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/fcs_factor.sv
// ---------------------------------------------------------------------------
// fcs_factor
// Smoothing factor 1 - exp(-smooth * dt) in Q1.16 on one shared multiplier.
// ---------------------------------------------------------------------------
module fcs_factor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] smooth,
	input  logic [15:0] dt,
	output logic [16:0] f,
	output logic        done
);
	import fcs_pkg::*;

	typedef enum logic [3:0] {
		F_IDLE, F_SETUP, F_H1, F_H2, F_DIV3, F_H3, F_H4, F_SQ1, F_SQ2, F_SQ3, F_EXP
	} fstate_t;

	fstate_t     state_q;
	logic [63:0] prod_q;
	logic [27:0] y_q;
	logic [4:0]  k_q;
	logic [4:0]  cnt_q;
	logic [16:0] f_q;
	logic        done_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [31:0] y32;
	logic [31:0] e_sq1;
	logic [32:0] fsum;

	assign y32   = {4'b0, y_q};
	assign e_sq1 = ONE_Q31 - prod_q[62:31];
	assign fsum  = {1'b0, ONE_Q31} - {1'b0, prod_q[62:31]} + 33'd16384;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			F_IDLE: begin
				mul_a = {16'b0, smooth};
				mul_b = {16'b0, dt};
			end
			F_SETUP: begin
				mul_a = {4'b0, prod_q[22:0], 5'b0};
				mul_b = RECIP5;
			end
			F_H1: begin
				mul_a = y32;
				mul_b = ONE_Q31 - {2'b0, prod_q[63:34]};
			end
			F_H2, F_H3: begin
				mul_a = y32;
				mul_b = ONE_Q31 - {1'b0, prod_q[63:33]};
			end
			F_DIV3: begin
				mul_a = prod_q[62:31];
				mul_b = RECIP3;
			end
			F_H4: begin
				mul_a = y32;
				mul_b = ONE_Q31 - prod_q[63:32];
			end
			F_SQ1: begin
				mul_a = e_sq1;
				mul_b = e_sq1;
			end
			F_SQ2, F_SQ3: begin
				mul_a = prod_q[62:31];
				mul_b = prod_q[62:31];
			end
			F_EXP: begin
				mul_a = prod_q[62:31];
				mul_b = EXP_M1_Q31;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= ((state_q == F_SETUP) && (|prod_q[31:28])) ||
				((state_q == F_EXP) && (cnt_q == k_q));
			case (state_q)
				F_IDLE: begin
					if (start) begin
						prod_q  <= prod;
						state_q <= F_SETUP;
					end
				end
				F_SETUP: begin
					// whole part of 32 or more: factor saturates
					if (|prod_q[31:28]) begin
						f_q     <= 17'h10000;
						state_q <= F_IDLE;
					end else begin
						k_q     <= prod_q[27:23];
						y_q     <= {prod_q[22:0], 5'b0};
						prod_q  <= prod;
						state_q <= F_H1;
					end
				end
				F_H1: begin
					prod_q  <= prod;
					state_q <= F_H2;
				end
				F_H2: begin
					prod_q  <= prod;
					state_q <= F_DIV3;
				end
				F_DIV3: begin
					prod_q  <= prod;
					state_q <= F_H3;
				end
				F_H3: begin
					prod_q  <= prod;
					state_q <= F_H4;
				end
				F_H4: begin
					prod_q  <= prod;
					state_q <= F_SQ1;
				end
				F_SQ1: begin
					prod_q  <= prod;
					state_q <= F_SQ2;
				end
				F_SQ2: begin
					prod_q  <= prod;
					state_q <= F_SQ3;
				end
				F_SQ3: begin
					prod_q  <= prod;
					cnt_q   <= '0;
					state_q <= F_EXP;
				end
				F_EXP: begin
					if (cnt_q == k_q) begin
						f_q     <= fsum[31:15];
						state_q <= F_IDLE;
					end else begin
						prod_q <= prod;
						cnt_q  <= cnt_q + 5'd1;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign f    = f_q;
	assign done = done_q;

endmodule

FILE: rtl/fcs_lane.sv
// ---------------------------------------------------------------------------
// fcs_lane
// One coordinate of one tracked point: desired value and exponential step.
// ---------------------------------------------------------------------------
module fcs_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  fcs_pkg::lane_ctrl_t ctrl,
	input  logic signed [31:0]  target,
	input  logic signed [31:0]  offset,
	input  logic [16:0]         f,
	output logic signed [31:0]  point
);
	import fcs_pkg::*;

	logic signed [31:0] desired_q;
	logic signed [31:0] cur_q;
	logic signed [50:0] prod_q;

	logic signed [35:0] des_sum;
	logic signed [32:0] diff;
	logic signed [17:0] fs;
	logic signed [50:0] prod;
	logic signed [50:0] rnd;
	logic signed [34:0] stepv;
	logic signed [35:0] upd_sum;

	assign des_sum = 36'(target) + 36'(offset);
	assign diff    = 33'(desired_q) - 33'(cur_q);
	assign fs      = $signed({1'b0, f});
	assign prod    = diff * fs;
	assign rnd     = prod_q + 51'sd32768;
	assign stepv   = 35'(rnd >>> 16);
	assign upd_sum = 36'(cur_q) + 36'(stepv);

	always_ff @(posedge clk) begin
		if (ctrl.load_des)
			desired_q <= sat32(des_sum);
		if (ctrl.mul)
			prod_q <= prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (ctrl.prime) begin
			cur_q <= desired_q;
		end else if (ctrl.upd) begin
			cur_q <= sat32(upd_sum);
		end
	end

	assign point = cur_q;

endmodule

FILE: rtl/fcs_angles.sv
// ---------------------------------------------------------------------------
// fcs_angles
// Merge stage: look direction normalize, CORDIC yaw and pitch in degrees.
// ---------------------------------------------------------------------------
module fcs_angles #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [32:0] d_x,
	input  logic signed [32:0] d_y,
	input  logic signed [32:0] d_z,
	output logic signed [15:0] yaw,
	output logic signed [14:0] pitch,
	output logic               degen,
	output logic               done
);
	import fcs_pkg::*;

	localparam int IW = $clog2(CORDIC_STEPS);

	typedef enum logic [2:0] {
		A_IDLE, A_NORM, A_YLOAD, A_YRUN, A_HMUL, A_PLOAD, A_PRUN, A_FIN
	} astate_t;

	astate_t            state_q;
	logic [2:0]         n_q;
	logic [63:0]        m_q;
	logic signed [63:0] vx_q, vy_q, vz_q;
	logic signed [63:0] cx_q, cy_q;
	logic signed [31:0] cz_q;
	logic               zero_q;
	logic [IW-1:0]      i_q;
	logic signed [63:0] h_q;
	logic signed [31:0] yawz_q;
	logic               degen_q;
	logic signed [15:0] yaw_q;
	logic signed [14:0] pitch_q;
	logic               done_q;

	logic [32:0]        ax, ay, az, m0;
	logic [5:0]         s;
	logic [63:0]        lim;
	logic signed [63:0] ld_x, ld_y;
	logic signed [63:0] dx, dy;
	logic signed [31:0] at;
	logic               last;
	logic [63:0]        hprod;
	logic signed [31:0] yaw_r, pitch_r;
	logic signed [22:0] yaw_v, pitch_v;

	assign ax = d_x[32] ? 33'(-d_x) : 33'(d_x);
	assign ay = d_y[32] ? 33'(-d_y) : 33'(d_y);
	assign az = d_z[32] ? 33'(-d_z) : 33'(d_z);

	always_comb begin
		m0 = ax;
		if (ay > m0)
			m0 = ay;
		if (az > m0)
			m0 = az;
	end

	// binary search for the shift that brings the largest component to [2^58, 2^59)
	assign s   = 6'd32 >> n_q;
	assign lim = 64'd1 << (7'd59 - 7'(s));

	assign ld_x = (state_q == A_YLOAD) ? vx_q : h_q;
	assign ld_y = (state_q == A_YLOAD) ? vz_q : vy_q;

	assign dx   = cy_q >>> i_q;
	assign dy   = cx_q >>> i_q;
	assign at   = $signed({10'b0, atan_deg_q16(5'(i_q))});
	assign last = (i_q == IW'(CORDIC_STEPS - 1));

	assign hprod = {20'b0, cx_q[63:20]} * {44'b0, INV_GAIN_Q20};

	assign yaw_r   = yawz_q + 32'sd256;
	assign pitch_r = cz_q + 32'sd256;
	assign yaw_v   = 23'(yaw_r >>> 9);
	assign pitch_v = 23'(pitch_r >>> 9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
			n_q     <= '0;
			i_q     <= '0;
		end else begin
			done_q <= (state_q == A_FIN);
			case (state_q)
				A_IDLE: begin
					if (start) begin
						vx_q    <= 64'(d_x);
						vy_q    <= 64'(d_y);
						vz_q    <= 64'(d_z);
						m_q     <= 64'(m0);
						n_q     <= '0;
						degen_q <= (m0 == '0);
						state_q <= (m0 == '0) ? A_FIN : A_NORM;
					end
				end
				A_NORM: begin
					if (m_q < lim) begin
						m_q  <= m_q << s;
						vx_q <= vx_q <<< s;
						vy_q <= vy_q <<< s;
						vz_q <= vz_q <<< s;
					end
					n_q <= n_q + 3'd1;
					if (n_q == 3'd5)
						state_q <= A_YLOAD;
				end
				A_YLOAD, A_PLOAD: begin
					zero_q <= (ld_x == '0) && (ld_y == '0);
					// left half plane: turn by 180 degrees first
					if (ld_x < 0) begin
						cx_q <= -ld_x;
						cy_q <= -ld_y;
						cz_q <= (ld_y < 0) ? -DEG180_Q16 : DEG180_Q16;
					end else begin
						cx_q <= ld_x;
						cy_q <= ld_y;
						cz_q <= '0;
					end
					i_q     <= '0;
					state_q <= (state_q == A_YLOAD) ? A_YRUN : A_PRUN;
				end
				A_YRUN, A_PRUN: begin
					if (!zero_q) begin
						if (cy_q > 0) begin
							cx_q <= cx_q + dx;
							cy_q <= cy_q - dy;
							cz_q <= cz_q + at;
						end else begin
							cx_q <= cx_q - dx;
							cy_q <= cy_q + dy;
							cz_q <= cz_q - at;
						end
					end
					i_q <= i_q + IW'(1);
					if (last)
						state_q <= (state_q == A_YRUN) ? A_HMUL : A_FIN;
				end
				A_HMUL: begin
					h_q     <= $signed(hprod);
					yawz_q  <= cz_q;
					state_q <= A_PLOAD;
				end
				A_FIN: begin
					if (degen_q) begin
						yaw_q   <= '0;
						pitch_q <= '0;
					end else begin
						if (yaw_v > 23'sd23040)
							yaw_q <= 16'sd23040;
						else if (yaw_v < -23'sd23040)
							yaw_q <= -16'sd23040;
						else
							yaw_q <= yaw_v[15:0];
						if (pitch_v > 23'sd11520)
							pitch_q <= 15'sd11520;
						else if (pitch_v < -23'sd11520)
							pitch_q <= -15'sd11520;
						else
							pitch_q <= pitch_v[14:0];
					end
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign yaw   = yaw_q;
	assign pitch = pitch_q;
	assign degen = degen_q;
	assign done  = done_q;

endmodule

FILE: rtl/follow_camera_smoother.sv
// ---------------------------------------------------------------------------
// follow_camera_smoother
// Six lanes smooth camera and look-at coordinates toward a tracked target;
// a merge stage turns the look direction into yaw and pitch.
// ---------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------
//  in      | in_valid/in_stall  | target_x/y/z, delta_time
//  out     | out_valid/out_stall| cam_x/y/z, yaw_deg, pitch_deg, degenerate
//  config  | APB psel/penable   | paddr, pwdata, prdata
//
//  One item at a time. The first item after reset skips the factor unit;
//  its run is set by the two CORDIC runs of the angle stage. Later items
//  add the factor unit, whose run grows with k, k being the whole part of
//  smoothness * delta_time (at most 31). No clearing pass after reset.
//  A finished result waits in the output register while the next item is taken.
// ---------------------------------------------------------------------------
module follow_camera_smoother #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic [15:0]        delta_time,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] cam_x,
	output logic signed [31:0] cam_y,
	output logic signed [31:0] cam_z,
	output logic signed [15:0] yaw_deg,
	output logic signed [14:0] pitch_deg,
	output logic               degenerate
);
	import fcs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_LOAD, S_FACT, S_MUL, S_UPD, S_ASTART, S_ANG, S_OUT
	} state_t;

	state_t             state_q;
	logic               primed_q;
	logic signed [31:0] offs_q [NUM_LANES];
	logic [15:0]        smooth_q;
	logic [15:0]        dt_q;
	logic               out_valid_q;
	logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
	logic signed [15:0] yaw_q;
	logic signed [14:0] pitch_q;
	logic               degen_q;

	logic               accept;
	logic               cfg_wr;
	lane_ctrl_t         lane_ctrl;
	logic signed [31:0] tgt [AXES];
	logic signed [31:0] pt [NUM_LANES];
	logic signed [32:0] d_x, d_y, d_z;
	logic [16:0]        fac_f;
	logic               fac_done;
	logic               fac_start;
	logic               ang_start;
	logic               ang_done;
	logic signed [15:0] ang_yaw;
	logic signed [14:0] ang_pitch;
	logic               ang_degen;
	logic               out_free;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_CAM_X:  prdata = offs_q[0];
			REG_CAM_Y:  prdata = offs_q[1];
			REG_CAM_Z:  prdata = offs_q[2];
			REG_LOOK_X: prdata = offs_q[3];
			REG_LOOK_Y: prdata = offs_q[4];
			REG_LOOK_Z: prdata = offs_q[5];
			REG_SMOOTH: prdata = {16'b0, smooth_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LANES; i++)
				offs_q[i] <= '0;
			smooth_q <= SMOOTH_RESET;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_CAM_X:  offs_q[0] <= pwdata;
				REG_CAM_Y:  offs_q[1] <= pwdata;
				REG_CAM_Z:  offs_q[2] <= pwdata;
				REG_LOOK_X: offs_q[3] <= pwdata;
				REG_LOOK_Y: offs_q[4] <= pwdata;
				REG_LOOK_Z: offs_q[5] <= pwdata;
				REG_SMOOTH: smooth_q  <= pwdata[15:0];
				default:    ;
			endcase
		end
	end

	assign tgt[0] = target_x;
	assign tgt[1] = target_y;
	assign tgt[2] = target_z;

	assign lane_ctrl.load_des = accept;
	assign lane_ctrl.prime    = (state_q == S_LOAD) && !primed_q;
	assign lane_ctrl.mul      = (state_q == S_MUL);
	assign lane_ctrl.upd      = (state_q == S_UPD);

	// lanes 0..2 camera x/y/z, lanes 3..5 look-at x/y/z
	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		fcs_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lane_ctrl),
			.target (tgt[l % AXES]),
			.offset (offs_q[l]),
			.f      (fac_f),
			.point  (pt[l])
		);
	end

	assign fac_start = (state_q == S_LOAD) && primed_q;

	fcs_factor u_factor (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fac_start),
		.smooth (smooth_q),
		.dt     (dt_q),
		.f      (fac_f),
		.done   (fac_done)
	);

	assign d_x = 33'(pt[3]) - 33'(pt[0]);
	assign d_y = 33'(pt[4]) - 33'(pt[1]);
	assign d_z = 33'(pt[5]) - 33'(pt[2]);

	assign ang_start = (state_q == S_ASTART);

	fcs_angles #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_angles (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ang_start),
		.d_x    (d_x),
		.d_y    (d_y),
		.d_z    (d_z),
		.yaw    (ang_yaw),
		.pitch  (ang_pitch),
		.degen  (ang_degen),
		.done   (ang_done)
	);

	always_ff @(posedge clk) begin
		if (accept)
			dt_q <= delta_time;
		if (state_q == S_OUT && out_free) begin
			cam_x_q <= pt[0];
			cam_y_q <= pt[1];
			cam_z_q <= pt[2];
			yaw_q   <= ang_yaw;
			pitch_q <= ang_pitch;
			degen_q <= ang_degen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			primed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_LOAD;
				end
				S_LOAD: begin
					// first item loads the points directly
					primed_q <= 1'b1;
					state_q  <= primed_q ? S_FACT : S_ASTART;
				end
				S_FACT: begin
					if (fac_done)
						state_q <= S_MUL;
				end
				S_MUL:    state_q <= S_UPD;
				S_UPD:    state_q <= S_ASTART;
				S_ASTART: state_q <= S_ANG;
				S_ANG: begin
					if (ang_done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign cam_x      = cam_x_q;
	assign cam_y      = cam_y_q;
	assign cam_z      = cam_z_q;
	assign yaw_deg    = yaw_q;
	assign pitch_deg  = pitch_q;
	assign degenerate = degen_q;

	a_fac_done_in_wait : assert property (@(posedge clk) disable iff (!arst_n)
		fac_done |-> state_q == S_FACT)
		else $error("factor finished outside its wait state");

	a_ang_done_in_wait : assert property (@(posedge clk) disable iff (!arst_n)
		ang_done |-> state_q == S_ANG)
		else $error("angle stage finished outside its wait state");

	a_degen_zero : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> yaw_deg == 16'sd0 && pitch_deg == 15'sd0)
		else $error("degenerate item carries nonzero angles");

	a_busy_after_accept : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input not stalled after an item was taken");

endmodule
